// File: hdl/lfo_pkg.sv
// Shared widths, codes, reset values, stage records and sine table function for the LFO.
package lfo_pkg;

	localparam int PHASE_W   = 32;
	localparam int STEP_W    = 31;
	localparam int WAVE_W    = 3;
	localparam int RAMP_W    = 25;
	localparam int CNT_W     = 13;
	localparam int VALUE_W   = 16;
	localparam int SINE_W    = 15;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;

	// phase span keeps one bit above the accumulator for the midpoint half-step
	localparam int PSPAN_W = PHASE_W + 1;
	localparam int RSPAN_W = RAMP_W + CNT_W;

	localparam int SINE_BITS_DEF = 10;
	localparam int MAX_BLOCK     = 4096;
	localparam int CNT_MAX_RAW   = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] MAX_CNT =
		CNT_W'((MAX_BLOCK > CNT_MAX_RAW) ? CNT_MAX_RAW : MAX_BLOCK);

	localparam logic [RAMP_W-1:0] RAMP_FULL = RAMP_W'(1 << 24);

	localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
	localparam logic [OP_W-1:0] OP_BLOCK     = 2'd1;
	localparam logic [OP_W-1:0] OP_RETRIG    = 2'd2;
	localparam logic [OP_W-1:0] OP_SET_PHASE = 2'd3;

	localparam logic [WAVE_W-1:0] WAVE_SINE    = 3'd0;
	localparam logic [WAVE_W-1:0] WAVE_TRI     = 3'd1;
	localparam logic [WAVE_W-1:0] WAVE_SAW     = 3'd2;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE  = 3'd3;
	localparam logic [WAVE_W-1:0] WAVE_RAMP_UP = 3'd4;
	localparam logic [WAVE_W-1:0] WAVE_RAMP_DN = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 2'd2;

	localparam logic [STEP_W-1:0] PHASE_STEP_RST = 31'd89478;
	localparam logic [WAVE_W-1:0] WAVEFORM_RST   = WAVE_SINE;
	localparam logic [RAMP_W-1:0] RAMP_STEP_RST  = 25'd350;

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic [WAVE_W-1:0] waveform;
		logic [RAMP_W-1:0] ramp_step;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [WAVE_W-1:0]  shape;
		logic [PSPAN_W-1:0] pspan;
		logic [RSPAN_W-1:0] rspan;
		logic [PHASE_W-1:0] new_phase;
	} span_t;

	typedef struct packed {
		logic [WAVE_W-1:0]  shape;
		logic [PHASE_W-1:0] mid_phase;
		logic [RAMP_W-1:0]  mid_ramp;
		logic [PHASE_W-1:0] phase;
		logic [RAMP_W-1:0]  ramp;
	} pos_t;

	// Quarter-wave sine entry, Q30 Taylor series to x^13, rounded to Q15.
	// Only evaluated at elaboration to build the table.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
		input int unsigned bits);
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		int k;
		x = (PI_HALF_Q30 * 64'(idx)) >> bits;
		term = x;
		sum = x;
		for (k = 1; k <= 6; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			case (k)
				1: begin
					term = term / 6;
				end
				2: begin
					term = term / 20;
				end
				3: begin
					term = term / 42;
				end
				4: begin
					term = term / 72;
				end
				5: begin
					term = term / 110;
				end
				default: begin
					term = term / 156;
				end
			endcase
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[SINE_W-1:0];
	endfunction

endpackage

// File: hdl/lfo_if.sv
// Channel interfaces of the LFO: operation items, results and register writes.
interface lfo_item_if import lfo_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [CNT_W-1:0]   sample_count;
	logic [PHASE_W-1:0] new_phase;

	modport source(output valid, op, sample_count, new_phase, input ready);
	modport sink(input valid, op, sample_count, new_phase, output ready);
endinterface

interface lfo_result_if import lfo_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [PHASE_W-1:0]        phase;
	logic [RAMP_W-1:0]         ramp_progress;

	modport source(output valid, value, phase, ramp_progress, input ready);
	modport sink(input valid, value, phase, ramp_progress, output ready);
endinterface

interface lfo_cfg_if import lfo_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/lfo_span.sv
// Input stage: count clamp and per-item phase and ramp span products.
module lfo_span import lfo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [OP_W-1:0]    op,
	input  logic [CNT_W-1:0]   sample_count,
	input  logic [PHASE_W-1:0] new_phase,
	input  cfg_t               cfg,
	input  logic               next_ready,
	output logic               ready,
	output logic               valid_s1,
	output span_t              span_s1
);

	localparam int PPROD_W = STEP_W + CNT_W;

	logic [CNT_W-1:0]   cnt;
	logic [PPROD_W-1:0] pprod;
	logic [RSPAN_W-1:0] rprod;
	logic [WAVE_W-1:0]  shape;

	// a tick is a block of one sample
	always_comb begin
		if (op == OP_TICK || sample_count == '0)
			cnt = CNT_W'(1);
		else if (sample_count > MAX_CNT)
			cnt = MAX_CNT;
		else
			cnt = sample_count;
	end

	assign pprod = PPROD_W'(cfg.phase_step) * PPROD_W'(cnt);
	assign rprod = RSPAN_W'(cfg.ramp_step) * RSPAN_W'(cnt);
	assign shape = (cfg.waveform > WAVE_RAMP_DN) ? WAVE_RAMP_DN : cfg.waveform;

	assign ready = !valid_s1 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			span_s1.op        <= op;
			span_s1.shape     <= shape;
			span_s1.pspan     <= pprod[PSPAN_W-1:0];
			span_s1.rspan     <= rprod;
			span_s1.new_phase <= new_phase;
		end
	end

endmodule

// File: hdl/lfo_accum.sv
// Phase and ramp accumulators, midpoint position and state update per item.
module lfo_accum import lfo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_s1,
	input  span_t span_s1,
	input  logic  next_ready,
	output logic  ready,
	output logic  valid_s2,
	output pos_t  pos_s2
);

	localparam int SUM_W = RSPAN_W + 1;

	logic [PHASE_W-1:0] phase_acc_q;
	logic [RAMP_W-1:0]  ramp_acc_q;
	logic               blk;
	logic               fire;
	logic               emits;
	logic [PHASE_W-1:0] mid_phase;
	logic [PHASE_W-1:0] phase_nx;
	logic [SUM_W-1:0]   half_r;
	logic [SUM_W-1:0]   sum_mid;
	logic [SUM_W-1:0]   sum_full;
	logic [RAMP_W-1:0]  mid_ramp;
	logic [RAMP_W-1:0]  ramp_nx;

	assign blk   = span_s1.op == OP_BLOCK;
	assign emits = span_s1.op == OP_TICK || span_s1.op == OP_BLOCK;
	assign ready = !valid_s2 || next_ready;
	assign fire  = valid_s1 && ready;

	// midpoint: half the span on a block, the current position on a tick
	assign mid_phase = phase_acc_q + (blk ? span_s1.pspan[PSPAN_W-1:1] : '0);
	assign half_r    = blk ? SUM_W'(span_s1.rspan >> 1) : '0;
	assign sum_mid   = SUM_W'(ramp_acc_q) + half_r;
	assign mid_ramp  = (sum_mid > SUM_W'(RAMP_FULL)) ? RAMP_FULL : sum_mid[RAMP_W-1:0];

	assign phase_nx = phase_acc_q + span_s1.pspan[PHASE_W-1:0];
	assign sum_full = SUM_W'(ramp_acc_q) + SUM_W'(span_s1.rspan);
	assign ramp_nx  = (sum_full > SUM_W'(RAMP_FULL)) ? RAMP_FULL : sum_full[RAMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			ramp_acc_q  <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (ready)
				valid_s2 <= valid_s1 && emits;
			if (fire) begin
				case (span_s1.op)
					OP_RETRIG: begin
						phase_acc_q <= '0;
						ramp_acc_q  <= '0;
					end
					OP_SET_PHASE: begin
						phase_acc_q <= span_s1.new_phase;
					end
					default: begin
						phase_acc_q <= phase_nx;
						ramp_acc_q  <= ramp_nx;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emits) begin
			pos_s2.shape     <= span_s1.shape;
			pos_s2.mid_phase <= mid_phase;
			pos_s2.mid_ramp  <= mid_ramp;
			pos_s2.phase     <= phase_nx;
			pos_s2.ramp      <= ramp_nx;
		end
	end

endmodule

// File: hdl/lfo_shaper.sv
// Sine table read and waveform shaping into the result register.
module lfo_shaper import lfo_pkg::*; #(
	parameter int SINE_BITS = SINE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s2,
	input  pos_t                      pos_s2,
	input  logic                      out_ready,
	output logic                      ready,
	output logic                      out_valid,
	output logic signed [VALUE_W-1:0] value,
	output logic [PHASE_W-1:0]        phase,
	output logic [RAMP_W-1:0]         ramp_progress
);

	localparam int ENTRIES = (1 << SINE_BITS) + 1;
	localparam int ADDR_W  = SINE_BITS + 1;

	typedef logic [SINE_W-1:0] rom_t [ENTRIES];

	function automatic rom_t build_rom();
		rom_t r;
		int i;
		for (i = 0; i < ENTRIES; i++)
			r[i] = sine_entry(i, SINE_BITS);
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic                   valid_s3;
	pos_t                   pos_s3;
	logic [SINE_W-1:0]      sine_s3;
	logic                   out_open;
	logic [SINE_BITS-1:0]   idx;
	logic [ADDR_W-1:0]      addr;
	logic [PHASE_W-1:0]     d;
	logic [PHASE_W-1:0]     p;
	logic [16:0]            r17;
	logic signed [17:0]     wide;
	logic signed [VALUE_W-1:0] sat;

	// odd quadrants run the table backwards
	assign idx  = pos_s2.mid_phase[PHASE_W-3 -: SINE_BITS];
	assign addr = pos_s2.mid_phase[PHASE_W-2] ? ADDR_W'(ENTRIES - 1) - ADDR_W'(idx)
		: ADDR_W'(idx);

	assign out_open = !out_valid || out_ready;
	assign ready    = !valid_s3 || out_open;

	assign p   = pos_s3.mid_phase;
	assign r17 = pos_s3.mid_ramp[RAMP_W-1:8];
	assign d   = p[PHASE_W-1] ? {1'b0, p[PHASE_W-2:0]} : 32'h8000_0000 - p;

	always_comb begin
		case (pos_s3.shape)
			WAVE_TRI: begin
				wide = 18'sd32768 - $signed({1'b0, d[PHASE_W-1:15]});
			end
			WAVE_SAW: begin
				wide = $signed({2'b00, p[PHASE_W-1:16]}) - 18'sd32768;
			end
			WAVE_SQUARE: begin
				wide = p[PHASE_W-1] ? -18'sd32768 : 18'sd32767;
			end
			WAVE_RAMP_UP: begin
				wide = $signed({1'b0, r17}) - 18'sd32768;
			end
			WAVE_RAMP_DN: begin
				wide = 18'sd32768 - $signed({1'b0, r17});
			end
			default: begin
				// sine; upper half negates
				wide = p[PHASE_W-1] ? -$signed({3'b000, sine_s3}) : $signed({3'b000, sine_s3});
			end
		endcase
		sat = (wide > 18'sd32767) ? 16'sd32767 : wide[VALUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready)
				valid_s3 <= valid_s2;
			if (out_open)
				out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s2) begin
			pos_s3  <= pos_s2;
			sine_s3 <= SINE_ROM[addr];
		end
		if (out_open && valid_s3) begin
			value         <= sat;
			phase         <= pos_s3.phase;
			ramp_progress <= pos_s3.ramp;
		end
	end

endmodule

// File: hdl/lfo_waveform_generator.sv
// Top level of the low-frequency oscillator: registers, span, accumulator and shaper stages.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  item    | in  | valid / ready | op, sample_count, new_phase
//  result  | out | valid / ready | value (Q1.15), phase, ramp_progress (Q1.24)
//  cfg     | in  | valid / ready | index, data (0 phase_step, 1 waveform, 2 ramp_step)
//
// One item per clock while no stage is held: a tick or block op passes through the span
// multiply, accumulate and sine table read registers, then shaping into the result
// register. Retrigger and set-phase give no result and leave the pipeline at stage two.
// arst_n clears the accumulators, registers and valid bits; no clearing pass.
// Each stage holds only while its successor is full and stalled, so bubbles are
// squeezed out and items keep being taken while a result waits on result.ready.
// cfg.ready is always high; a write to an index beyond the list is dropped.
module lfo_waveform_generator import lfo_pkg::*; #(
	parameter int SINE_BITS = SINE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lfo_item_if.sink     item,
	lfo_result_if.source result,
	lfo_cfg_if.sink      cfg
);

	cfg_t  cfg_q;
	logic  valid_s1;
	span_t span_s1;
	logic  valid_s2;
	pos_t  pos_s2;
	logic  ready_s2;
	logic  ready_s3;

	// configuration registers; the user must write them only while the pipeline is empty (not enforced here)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= PHASE_STEP_RST;
			cfg_q.waveform   <= WAVEFORM_RST;
			cfg_q.ramp_step  <= RAMP_STEP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PHASE_STEP: begin
					cfg_q.phase_step <= cfg.data[STEP_W-1:0];
				end
				CFG_WAVEFORM: begin
					cfg_q.waveform <= cfg.data[WAVE_W-1:0];
				end
				CFG_RAMP_STEP: begin
					cfg_q.ramp_step <= cfg.data[RAMP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1: clamp the count, multiply step by count
	lfo_span u_span (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (item.valid),
		.op           (item.op),
		.sample_count (item.sample_count),
		.new_phase    (item.new_phase),
		.cfg          (cfg_q),
		.next_ready   (ready_s2),
		.ready        (item.ready),
		.valid_s1     (valid_s1),
		.span_s1      (span_s1)
	);

	// stage 2: midpoint and state advance; the only place the accumulators change
	lfo_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.span_s1    (span_s1),
		.next_ready (ready_s3),
		.ready      (ready_s2),
		.valid_s2   (valid_s2),
		.pos_s2     (pos_s2)
	);

	// stages 3 and 4: table read, then shape and saturate into the result register
	lfo_shaper #(
		.SINE_BITS (SINE_BITS)
	) u_shaper (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.pos_s2        (pos_s2),
		.out_ready     (result.ready),
		.ready         (ready_s3),
		.out_valid     (result.valid),
		.value         (result.value),
		.phase         (result.phase),
		.ramp_progress (result.ramp_progress)
	);

endmodule

// File: hdl/lfo_chk.sv
// Port-level checks on the LFO and their binding to the top level.
module lfo_chk import lfo_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	lfo_item_if.sink item,
	lfo_result_if.source result,
	lfo_cfg_if.sink  cfg
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.value)
			&& $stable(result.phase) && $stable(result.ramp_progress))
		else $error("result changed while stalled");

	// ramp progress saturates at one
	a_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.ramp_progress <= RAMP_FULL)
		else $error("ramp progress above full scale");

	// an empty result register never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> item.ready)
		else $error("input stalled with empty output");

	// register writes are never refused
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready)
		else $error("register write refused");

endmodule

bind lfo_waveform_generator lfo_chk u_lfo_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result),
	.cfg    (cfg)
);

// File: tb/lfo_waveform_generator_tb.sv
// Self-checking testbench for the LFO: directed shape and block cases, then randomized traffic.
module lfo_waveform_generator_tb;
	import lfo_pkg::*;

	// Model-side constants: quarter-wave table size, ramp full scale, block clamp.
	localparam int                 SINE_TABLE_BITS = 10;
	localparam int                 QUARTER_SIZE    = (1 << SINE_TABLE_BITS) + 1;
	localparam longint unsigned    HALF_PI_Q30     = 64'd1686629713;
	localparam longint unsigned    RAMP_ONE        = 64'd16777216;
	localparam longint unsigned    BLOCK_LIMIT     = 64'd4096;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
	// Tick to result is four stages; drains settle for longer than that before a register write.
	localparam int                 PIPE_DEPTH      = 4;
	localparam int                 SETTLE_CYCLES   = PIPE_DEPTH + 4;
	localparam int                 DRAIN_LIMIT     = 5000;
	localparam int                 IDLE_PCT        = 11;
	localparam int                 REPORT_LIMIT    = 10;
	localparam int                 RANDOM_PHASES   = 8;
	localparam int                 ITEMS_PER_PHASE = 107;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [PHASE_W-1:0]        phase;
		logic [RAMP_W-1:0]         ramp_progress;
	} lfo_sample_t;

	logic clk;
	logic arst_n;

	lfo_item_if   item_ch();
	lfo_result_if res_ch();
	lfo_cfg_if    cfg_ch();

	lfo_waveform_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the oscillator: registers and both accumulators.
	logic [STEP_W-1:0]  step_shadow;
	logic [WAVE_W-1:0]  wave_shadow;
	logic [RAMP_W-1:0]  ramp_step_shadow;
	logic [PHASE_W-1:0] phase_shadow;
	logic [RAMP_W-1:0]  progress_shadow;

	logic signed [VALUE_W-1:0] quarter_sine [QUARTER_SIZE];

	lfo_sample_t expected_samples[$];
	int          fail_count;
	bit          steady_flow;   // when set, neither side idles

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed time bound on the whole run.
	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Quarter-wave sine in Q15: Q30 Taylor series to x^13, rounded, capped at full scale.
	task automatic fill_quarter_sine();
		longint unsigned x;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned q15;
		longint unsigned div;
		for (int i = 0; i < QUARTER_SIZE; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
			term = x;
			acc = x;
			for (int k = 1; k <= 6; k++) begin
				div = longint'(2 * k) * longint'(2 * k + 1);
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / div;
				if (k % 2 == 1)
					acc = acc - term;
				else
					acc = acc + term;
			end
			q15 = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
			if (q15 > 64'd32767)
				q15 = 64'd32767;
			quarter_sine[i] = VALUE_W'(q15);
		end
	endtask

	function automatic int clip_top(input int v);
		return (v > 32767) ? 32767 : v;
	endfunction

	// Cyclic shapes read straight from the phase word.
	function automatic int cyclic_level(input logic [PHASE_W-1:0] p, input logic [WAVE_W-1:0] shape);
		logic [PHASE_W-1:0] gap;
		int                 idx;
		int                 s;
		case (shape)
			WAVE_TRI: begin
				gap = p[31] ? (p - 32'h8000_0000) : (32'h8000_0000 - p);
				return clip_top(32768 - int'(gap >> 15));
			end
			WAVE_SAW: begin
				return int'(p >> 16) - 32768;
			end
			WAVE_SQUARE: begin
				return p[31] ? -32768 : 32767;
			end
			default: begin
				// truncated table index within the quadrant; odd quadrants mirror,
				// the second half of the circle negates
				idx = int'(p[29:0] >> (30 - SINE_TABLE_BITS));
				if (p[30])
					idx = (1 << SINE_TABLE_BITS) - idx;
				s = int'(quarter_sine[idx]);
				return p[31] ? -s : s;
			end
		endcase
	endfunction

	// Ramps are a bipolar line over progress 0 .. 1.0 (Q1.24).
	function automatic int ramp_level(input logic [RAMP_W-1:0] prog, input bit falling);
		int r;
		r = int'(prog >> 8);
		return clip_top(falling ? (32768 - r) : (r - 32768));
	endfunction

	function automatic logic [RAMP_W-1:0] ramp_sat_add(input logic [RAMP_W-1:0] base,
		input logic [63:0] amount);
		logic [63:0] total;
		total = 64'(base) + amount;
		return (total > RAMP_ONE) ? RAMP_W'(RAMP_ONE) : total[RAMP_W-1:0];
	endfunction

	// Advance the shadow oscillator by one accepted item; queue the sample it emits.
	task automatic advance_lfo(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] cnt,
		input logic [PHASE_W-1:0] load_phase);
		logic [WAVE_W-1:0]  shape;
		logic [63:0]        samples;
		logic [63:0]        pspan;
		logic [63:0]        rspan;
		logic [PHASE_W-1:0] mid_phase;
		bit                 is_ramp;
		int                 level;
		lfo_sample_t        s;
		// codes 6 and 7 behave as ramp down
		shape = (wave_shadow > WAVE_RAMP_DN) ? WAVE_RAMP_DN : wave_shadow;
		is_ramp = (shape >= WAVE_RAMP_UP);
		case (op)
			OP_RETRIG: begin
				phase_shadow = '0;
				progress_shadow = '0;
			end
			OP_SET_PHASE: begin
				phase_shadow = load_phase;
			end
			default: begin
				if (op == OP_TICK) begin
					// value at the current position, then one sample on
					level = is_ramp ? ramp_level(progress_shadow, shape == WAVE_RAMP_DN)
						: cyclic_level(phase_shadow, shape);
					phase_shadow = phase_shadow + PHASE_W'(step_shadow);
					progress_shadow = ramp_sat_add(progress_shadow, 64'(ramp_step_shadow));
				end else begin
					// block: zero counts as one, long blocks clamp to the limit
					samples = (cnt == '0) ? 64'd1 : 64'(cnt);
					if (samples > BLOCK_LIMIT)
						samples = BLOCK_LIMIT;
					pspan = 64'(step_shadow) * samples;
					rspan = 64'(ramp_step_shadow) * samples;
					mid_phase = phase_shadow + pspan[32:1];
					level = is_ramp
						? ramp_level(ramp_sat_add(progress_shadow, rspan >> 1),
							shape == WAVE_RAMP_DN)
						: cyclic_level(mid_phase, shape);
					phase_shadow = phase_shadow + pspan[31:0];
					progress_shadow = ramp_sat_add(progress_shadow, rspan);
				end
				s.value = level[VALUE_W-1:0];
				s.phase = phase_shadow;
				s.ramp_progress = progress_shadow;
				expected_samples.push_back(s);
			end
		endcase
	endtask

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// One item transfer. Valid stays high on return so back-to-back items need no gap.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] cnt,
		input logic [PHASE_W-1:0] load_phase);
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			// idle cycle with junk on the payload
			item_ch.valid = 1'b0;
			item_ch.op = OP_W'($urandom());
			item_ch.sample_count = CNT_W'($urandom());
			item_ch.new_phase = $urandom();
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.op = op;
		item_ch.sample_count = cnt;
		item_ch.new_phase = load_phase;
		do
			@(posedge clk);
		while (!item_ch.ready);
		advance_lfo(op, cnt, load_phase);
	endtask

	// Register write; only called with the pipeline empty.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			CFG_PHASE_STEP: step_shadow = data[STEP_W-1:0];
			CFG_WAVEFORM:   wave_shadow = data[WAVE_W-1:0];
			CFG_RAMP_STEP:  ramp_step_shadow = data[RAMP_W-1:0];
			default: ;      // out-of-range index is dropped
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Stop sending, wait for every pending sample, then let retrigger / set-phase
	// items that emit nothing clear the pipe.
	task automatic drain_pipeline();
		int guard;
		guard = 0;
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (expected_samples.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		while (expected_samples.size() != 0) begin
			void'(expected_samples.pop_front());
			flag_error("sample expected but never delivered");
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset register values: ticks, block count edge cases, retrigger.
	task automatic test_reset_defaults();
		send_item(OP_TICK, '0, '0);
		send_item(OP_BLOCK, '0, '0);
		send_item(OP_BLOCK, CNT_W'(8191), '0);
		send_item(OP_BLOCK, CNT_W'(4096), '0);
		send_item(OP_RETRIG, '0, '0);
		send_item(OP_TICK, '0, '0);
		drain_pipeline();
	endtask

	// Every waveform code (6 and 7 too) at extreme phases, max step, ramp step 0 / max.
	task automatic test_each_waveform();
		logic [PHASE_W-1:0] corner [8];
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h4000_0000, 32'hC000_0000, 32'h3FFF_FFFF, 32'h0000_0000};
		write_reg(CFG_UNUSED, '1);
		write_reg(CFG_PHASE_STEP, CFG_DATA_W'(32'h7FFF_FFFF));
		for (int w = 0; w < 8; w++) begin
			write_reg(CFG_WAVEFORM, CFG_DATA_W'(w));
			write_reg(CFG_RAMP_STEP, (w % 2 == 1) ? CFG_DATA_W'(25'h1FF_FFFF) : '0);
			send_item(OP_SET_PHASE, '0, corner[w]);
			if (w % 2 == 0)
				send_item(OP_TICK, '0, '0);
			else
				send_item(OP_BLOCK, CNT_W'(8191), '0);
			drain_pipeline();
		end
	endtask

	task automatic pick_settings();
		int sel;
		sel = $urandom_range(0, 4);
		case (sel)
			0: write_reg(CFG_PHASE_STEP, '0);
			1: write_reg(CFG_PHASE_STEP, CFG_DATA_W'(32'h7FFF_FFFF));
			2: write_reg(CFG_PHASE_STEP, CFG_DATA_W'($urandom_range(1, 2000000)));
			default: write_reg(CFG_PHASE_STEP, CFG_DATA_W'($urandom()));
		endcase
		// random upper bits ride along with the waveform code
		write_reg(CFG_WAVEFORM, CFG_DATA_W'(($urandom() & ~32'd7) | $urandom_range(0, 7)));
		sel = $urandom_range(0, 6);
		case (sel)
			0: write_reg(CFG_RAMP_STEP, '0);
			1: write_reg(CFG_RAMP_STEP, CFG_DATA_W'(1));
			2: write_reg(CFG_RAMP_STEP, CFG_DATA_W'(RAMP_ONE));
			3: write_reg(CFG_RAMP_STEP, CFG_DATA_W'(25'h1FF_FFFF));
			4: write_reg(CFG_RAMP_STEP, CFG_DATA_W'($urandom_range(1, 200000)));
			default: write_reg(CFG_RAMP_STEP, CFG_DATA_W'($urandom() & 32'h1FF_FFFF));
		endcase
	endtask

	// Random mix: mostly ticks and short blocks, some retrigger and phase loads.
	task automatic test_random_traffic();
		int               pick;
		logic [OP_W-1:0]  op;
		logic [CNT_W-1:0] cnt;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick_settings();
			steady_flow = (ph == RANDOM_PHASES / 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					op = OP_TICK;
				else if (pick < 80)
					op = OP_BLOCK;
				else if (pick < 88)
					op = OP_RETRIG;
				else
					op = OP_SET_PHASE;
				pick = $urandom_range(0, 9);
				if (pick < 7)
					cnt = CNT_W'($urandom_range(0, 64));
				else if (pick < 9)
					cnt = CNT_W'($urandom_range(0, 4096));
				else
					cnt = CNT_W'($urandom());
				send_item(op, cnt, $urandom());
			end
			drain_pipeline();
			steady_flow = 1'b0;
		end
	endtask

	// Result side stalls at random, except during the steady stretch.
	always @(negedge clk) begin
		res_ch.ready = steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Every result transfer is checked against the oldest pending sample.
	always @(posedge clk) begin : sample_check
		lfo_sample_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_samples.size() == 0) begin
				flag_error($sformatf("unexpected result: value %0d phase %h progress %h",
					res_ch.value, res_ch.phase, res_ch.ramp_progress));
			end else begin
				want = expected_samples.pop_front();
				if (res_ch.value !== want.value || res_ch.phase !== want.phase ||
					res_ch.ramp_progress !== want.ramp_progress) begin
					flag_error($sformatf(
						"exp value %0d phase %h progress %h, got value %0d phase %h progress %h",
						want.value, want.phase, want.ramp_progress,
						res_ch.value, res_ch.phase, res_ch.ramp_progress));
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		steady_flow = 1'b0;
		step_shadow = PHASE_STEP_RST;
		wave_shadow = WAVEFORM_RST;
		ramp_step_shadow = RAMP_STEP_RST;
		phase_shadow = '0;
		progress_shadow = '0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_TICK;
		item_ch.sample_count = '0;
		item_ch.new_phase = '0;
		res_ch.ready = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_PHASE_STEP;
		cfg_ch.data = '0;
		fill_quarter_sine();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_each_waveform();
		test_random_traffic();
		drain_pipeline();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
